/* rtl/core/hbr_pkg.sv */
`default_nettype none
package hbr_pkg;
	localparam int SlotFields = 6;
	localparam int KeySlotsDefault = 6;
	localparam int ModBits = 8;
	localparam logic [7:0] BreakBit = 8'h80;
	localparam logic [7:0] ModUsageBase = 8'hE0;
	localparam logic [6:0] MinLength = 7'd8;

	// One lane's finding: a code to send, and whether it counts.
	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} lane_t;

	// Usage to Set-1 lookup; unmapped usages give zero.
	function automatic logic [7:0] map_usage(input logic [7:0] u);
		logic [7:0] r;
		r = 8'h00;
		case (u)
			8'h04: r = 8'h1E; 8'h05: r = 8'h30; 8'h06: r = 8'h2E; 8'h07: r = 8'h20;
			8'h08: r = 8'h12; 8'h09: r = 8'h21; 8'h0A: r = 8'h22; 8'h0B: r = 8'h23;
			8'h0C: r = 8'h17; 8'h0D: r = 8'h24; 8'h0E: r = 8'h25; 8'h0F: r = 8'h26;
			8'h10: r = 8'h32; 8'h11: r = 8'h31; 8'h12: r = 8'h18; 8'h13: r = 8'h19;
			8'h14: r = 8'h10; 8'h15: r = 8'h13; 8'h16: r = 8'h1F; 8'h17: r = 8'h14;
			8'h18: r = 8'h16; 8'h19: r = 8'h2F; 8'h1A: r = 8'h11; 8'h1B: r = 8'h2D;
			8'h1C: r = 8'h15; 8'h1D: r = 8'h2C;
			8'h1E: r = 8'h02; 8'h1F: r = 8'h03; 8'h20: r = 8'h04; 8'h21: r = 8'h05;
			8'h22: r = 8'h06; 8'h23: r = 8'h07; 8'h24: r = 8'h08; 8'h25: r = 8'h09;
			8'h26: r = 8'h0A; 8'h27: r = 8'h0B;
			8'h28: r = 8'h1C; 8'h29: r = 8'h01; 8'h2A: r = 8'h0E; 8'h2B: r = 8'h0F;
			8'h2C: r = 8'h39; 8'h2D: r = 8'h0C; 8'h2E: r = 8'h0D; 8'h2F: r = 8'h1A;
			8'h30: r = 8'h1B; 8'h31: r = 8'h2B; 8'h32: r = 8'h56; 8'h33: r = 8'h27;
			8'h34: r = 8'h28; 8'h35: r = 8'h29; 8'h36: r = 8'h33; 8'h37: r = 8'h34;
			8'h38: r = 8'h35;
			8'h39: r = 8'h3A; 8'h3A: r = 8'h3B; 8'h3B: r = 8'h3C; 8'h3C: r = 8'h3D;
			8'h3D: r = 8'h3E; 8'h3E: r = 8'h3F; 8'h3F: r = 8'h40; 8'h40: r = 8'h41;
			8'h41: r = 8'h42; 8'h42: r = 8'h43; 8'h43: r = 8'h44; 8'h44: r = 8'h57;
			8'h45: r = 8'h58; 8'h47: r = 8'h46;
			8'h49: r = 8'h52; 8'h4A: r = 8'h47; 8'h4B: r = 8'h49; 8'h4C: r = 8'h53;
			8'h4D: r = 8'h4F; 8'h4E: r = 8'h51; 8'h4F: r = 8'h4D; 8'h50: r = 8'h4B;
			8'h51: r = 8'h50; 8'h52: r = 8'h48;
			8'h53: r = 8'h45; 8'h54: r = 8'h35; 8'h55: r = 8'h37; 8'h56: r = 8'h4A;
			8'h57: r = 8'h4E; 8'h58: r = 8'h1C; 8'h59: r = 8'h4F; 8'h5A: r = 8'h50;
			8'h5B: r = 8'h51; 8'h5C: r = 8'h4B; 8'h5D: r = 8'h4C; 8'h5E: r = 8'h4D;
			8'h5F: r = 8'h47; 8'h60: r = 8'h48; 8'h61: r = 8'h49; 8'h62: r = 8'h52;
			8'h63: r = 8'h53; 8'h65: r = 8'h5D;
			8'hE0: r = 8'h1D; 8'hE1: r = 8'h2A; 8'hE2: r = 8'h38; 8'hE3: r = 8'h5B;
			8'hE4: r = 8'h1D; 8'hE5: r = 8'h36; 8'hE6: r = 8'h38; 8'hE7: r = 8'h5C;
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/hbr_if.sv */
`default_nettype none
// Report beat carrier.
interface hbr_report_if;
	logic       valid;
	logic       ready;
	logic [6:0] report_length;
	logic [7:0] modifiers;
	logic [7:0] key_slot_0;
	logic [7:0] key_slot_1;
	logic [7:0] key_slot_2;
	logic [7:0] key_slot_3;
	logic [7:0] key_slot_4;
	logic [7:0] key_slot_5;
	modport source (output valid, report_length, modifiers, key_slot_0, key_slot_1,
		key_slot_2, key_slot_3, key_slot_4, key_slot_5, input ready);
	modport sink (input valid, report_length, modifiers, key_slot_0, key_slot_1,
		key_slot_2, key_slot_3, key_slot_4, key_slot_5, output ready);
endinterface

// Scancode beat carrier.
interface hbr_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] scancode;
	logic       last_of_run;
	modport source (output valid, scancode, last_of_run, input ready);
	modport sink (input valid, scancode, last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/core/hbr_key_lane.sv */
`default_nettype none
// One slot lane: finds a release of its old usage and a press of its new one.
module hbr_key_lane #(
	parameter int N = 6
) (
	input  wire logic [7:0]         old_key,
	input  wire logic [7:0]         new_key,
	input  wire logic [N-1:0][7:0]  old_keys,
	input  wire logic [N-1:0][7:0]  new_keys,
	output hbr_pkg::lane_t          rel,
	output hbr_pkg::lane_t          prs
);
	import hbr_pkg::*;
	logic in_new, in_old;
	logic [7:0] old_code, new_code;

	// Membership of each usage in the other report.
	always_comb begin
		in_new = 1'b0;
		in_old = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (new_keys[i] == old_key) in_new = 1'b1;
			if (old_keys[i] == new_key) in_old = 1'b1;
		end
	end

	assign old_code = map_usage(old_key);
	assign new_code = map_usage(new_key);
	assign rel.hit  = (old_key != 8'h00) && !in_new && (old_code != 8'h00);
	assign rel.code = old_code | BreakBit;
	assign prs.hit  = (new_key != 8'h00) && !in_old && (new_code != 8'h00);
	assign prs.code = new_code;
endmodule
`default_nettype wire

/* rtl/core/hbr_merge.sv */
`default_nettype none
// Merging stage: holds the ordered list of found codes and sends one a beat.
module hbr_merge #(
	parameter int W = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  hbr_pkg::lane_t [W-1:0] lanes,
	output logic                   busy,
	hbr_code_if.source             code
);
	import hbr_pkg::*;
	logic [W-1:0]      hit_q;
	logic [W-1:0][7:0] code_q;
	logic [W-1:0]      sel;
	logic [W-1:0]      rest;
	logic [7:0]        pick;

	// Lowest pending entry goes first.
	always_comb begin
		sel  = hit_q & (~hit_q + W'(1));
		rest = hit_q & ~sel;
		pick = 8'h00;
		for (int i = 0; i < W; i++)
			if (sel[i]) pick = code_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (load) begin
			for (int i = 0; i < W; i++) hit_q[i] <= lanes[i].hit;
		end else if (code.valid && code.ready) begin
			hit_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			for (int i = 0; i < W; i++) code_q[i] <= lanes[i].code;
	end

	assign busy             = |hit_q;
	assign code.valid       = |hit_q;
	assign code.scancode    = pick;
	assign code.last_of_run = (rest == '0);
endmodule
`default_nettype wire

/* rtl/core/hid_boot_report_to_set1_scancodes_unit.sv */
`default_nettype none
// Translates USB HID boot keyboard reports into PS/2 Set-1 scancodes. A report is
// compared combinationally against the stored one by one lane per modifier bit and
// two per key slot; the found codes are then sent one per cycle while the sink is
// ready, in order: modifiers, releases, presses. A report causes up to 20 scancodes
// (six key slots), registered in the merging stage; the next report is taken once
// the last beat leaves. Short or repeated reports are dropped.
module hid_boot_report_to_set1_scancodes_unit #(
	parameter int KEY_SLOTS = hbr_pkg::KeySlotsDefault
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hbr_report_if.sink report,
	hbr_code_if.source code
);
	import hbr_pkg::*;
	localparam int N = (KEY_SLOTS < SlotFields) ? KEY_SLOTS : SlotFields;
	localparam int W = ModBits + 2 * N;

	logic [7:0]                   prev_mods_q;
	logic [N-1:0][7:0]            prev_keys_q;
	logic [SlotFields-1:0][7:0]   all_keys;
	logic [N-1:0][7:0]            new_keys;
	lane_t [ModBits-1:0]          mod_lanes;
	lane_t [N-1:0]                rel_lanes;
	lane_t [N-1:0]                prs_lanes;
	lane_t [W-1:0]                lanes;
	logic                         busy, take, keep, load;

	assign all_keys = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
		report.key_slot_2, report.key_slot_1, report.key_slot_0};
	assign new_keys = all_keys[N-1:0];

	assign report.ready = !busy;
	assign take = report.valid && report.ready;
	assign keep = (report.report_length >= MinLength) &&
		((report.modifiers != prev_mods_q) || (new_keys != prev_keys_q));
	assign load = take && keep;

	// Modifier lanes.
	always_comb begin
		logic [7:0] mc;
		for (int i = 0; i < ModBits; i++) begin
			mc = map_usage(ModUsageBase + 8'(i));
			mod_lanes[i].hit  = (report.modifiers[i] != prev_mods_q[i]) && (mc != 8'h00);
			mod_lanes[i].code = report.modifiers[i] ? mc : (mc | BreakBit);
		end
	end

	// Key slot lanes: releases first, then presses.
	for (genvar g = 0; g < N; g++) begin : g_lane
		hbr_key_lane #(.N(N)) u_lane (
			.old_key  (prev_keys_q[g]),
			.new_key  (new_keys[g]),
			.old_keys (prev_keys_q),
			.new_keys (new_keys),
			.rel      (rel_lanes[g]),
			.prs      (prs_lanes[g])
		);
	end

	// Lane order seen by the merging stage: modifiers, releases, presses.
	assign lanes = {prs_lanes, rel_lanes, mod_lanes};

	// Previous report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else if (load) begin
			prev_mods_q <= report.modifiers;
			prev_keys_q <= new_keys;
		end
	end

	hbr_merge #(.W(W)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.lanes  (lanes),
		.busy   (busy),
		.code   (code)
	);
endmodule
`default_nettype wire
